// File: design/alle_pkg.sv
// Shared constants and codes for the array linked list engine.
package alle_pkg;

  localparam int unsigned SLOTS_DEF      = 1024;
  localparam int unsigned VALUE_BITS_DEF = 32;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned IN_VAL_W = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned SLOT_W   = 10;
  localparam int unsigned COUNT_W  = 11;

  localparam logic [OP_W-1:0] OP_FRONT  = 2'd0;
  localparam logic [OP_W-1:0] OP_REAR   = 2'd1;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

endpackage

// File: design/alle_ram.sv
// Generic single write port, single read port RAM with a registered read.
module alle_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// File: design/array_linked_list_engine.sv
// Top level of the array linked list engine: sequencer, list registers and node memories.
//
// A singly linked list lives in a memory of node values and one of next links;
// a third memory holds a stack of freed slots. Each input transaction (in_op,
// in_value) inserts at the front, inserts at the rear, or deletes the first node
// holding the value, and yields exactly one result transaction with the status,
// the slot filled or freed, and the node count after it. Both channels use
// valid and stall; a transaction moves on a rising edge with valid high and
// stall low. The block takes one request at a time and stalls the input until
// the result is registered.
// Path of a request: a front insert from a never-used slot writes the node in
// S_LINK and hands its result over in S_FIN; a rear insert into a non-empty
// list first walks to the tail in S_WALK, and either insert passes S_POP when
// its slot comes off the free stack. A delete walks in S_DEL to its match, or
// the whole list if the value is absent; a refused insert or a delete on an
// empty list goes straight to S_FIN. The walk reads one node per cycle. The
// next request is taken after the result is registered, even while the receiver
// stalls it; a finished result waits for the output register to empty first.
// After reset the list is empty, no slot is in use and nothing is pending; the
// memories need no clearing pass, as no entry is read before it is written.
module array_linked_list_engine #(
  parameter int unsigned SLOTS      = alle_pkg::SLOTS_DEF,
  parameter int unsigned VALUE_BITS = alle_pkg::VALUE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [alle_pkg::OP_W-1:0]           in_op,
  input  logic signed [alle_pkg::IN_VAL_W-1:0] in_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [alle_pkg::STATUS_W-1:0]       out_status,
  output logic [alle_pkg::SLOT_W-1:0]         out_slot,
  output logic [alle_pkg::COUNT_W-1:0]        out_count
);

  // Slot index width, and link width, which also holds the null marker SLOTS.
  localparam int unsigned SW = $clog2(SLOTS);
  localparam int unsigned LW = $clog2(SLOTS + 1);
  localparam logic [LW-1:0] NULL_LINK = LW'(SLOTS);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_POP  = 6'b000010,
    S_LINK = 6'b000100,
    S_WALK = 6'b001000,
    S_DEL  = 6'b010000,
    S_FIN  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic                  front_r, front_nxt;
  logic [VALUE_BITS-1:0] val_r, val_nxt;
  logic [SW-1:0]         s_r, s_nxt;
  logic [LW-1:0]         p_r, p_nxt;
  logic [LW-1:0]         prev_r, prev_nxt;
  logic [LW-1:0]         head_r, head_nxt;
  logic [LW-1:0]         free_top_r, free_top_nxt;
  logic [LW-1:0]         fresh_next_r, fresh_next_nxt;
  logic [LW-1:0]         count_r, count_nxt;
  logic [alle_pkg::STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [SW-1:0]         res_slot_r, res_slot_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic [alle_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [alle_pkg::SLOT_W-1:0]   out_slot_r, out_slot_nxt;
  logic [alle_pkg::COUNT_W-1:0]  out_count_r, out_count_nxt;

  // Memory ports.  The value and link memories share one read address.
  logic                  val_we;
  logic [SW-1:0]         val_waddr;
  logic [VALUE_BITS-1:0] val_rdata;
  logic                  nxt_we;
  logic [SW-1:0]         nxt_waddr;
  logic [LW-1:0]         nxt_wdata;
  logic [LW-1:0]         nxt_rdata;
  logic [SW-1:0]         node_raddr;
  logic                  free_we;
  logic [SW-1:0]         free_waddr;
  logic [SW-1:0]         free_raddr;
  logic [SW-1:0]         free_rdata;

  logic                  accept;
  logic                  in_is_insert;
  logic signed [63:0]    in_value_ext;
  logic                  out_room;
  logic                  next_is_null;
  logic [LW-1:0]         free_top_dec;

  alle_ram #(.WIDTH(VALUE_BITS), .DEPTH(SLOTS)) u_value_ram (
    .clk     (clk),
    .wr_en   (val_we),
    .wr_addr (val_waddr),
    .wr_data (val_r),
    .rd_addr (node_raddr),
    .rd_data (val_rdata)
  );

  alle_ram #(.WIDTH(LW), .DEPTH(SLOTS)) u_next_ram (
    .clk     (clk),
    .wr_en   (nxt_we),
    .wr_addr (nxt_waddr),
    .wr_data (nxt_wdata),
    .rd_addr (node_raddr),
    .rd_data (nxt_rdata)
  );

  alle_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_free_ram (
    .clk     (clk),
    .wr_en   (free_we),
    .wr_addr (free_waddr),
    .wr_data (p_r[SW-1:0]),
    .rd_addr (free_raddr),
    .rd_data (free_rdata)
  );

  assign in_stall     = (state_r != S_IDLE);
  assign accept       = in_valid && (state_r == S_IDLE);
  assign in_is_insert = (in_op == alle_pkg::OP_FRONT) || (in_op == alle_pkg::OP_REAR);
  // Values are sign-extended from the port width, then kept in VALUE_BITS bits.
  assign in_value_ext = 64'(in_value);
  assign out_room     = !out_valid_r || !out_stall;
  assign next_is_null = (nxt_rdata >= NULL_LINK);
  assign free_top_dec = free_top_r - 1'b1;

  always_comb begin
    state_nxt      = state_r;
    front_nxt      = front_r;
    val_nxt        = val_r;
    s_nxt          = s_r;
    p_nxt          = p_r;
    prev_nxt       = prev_r;
    head_nxt       = head_r;
    free_top_nxt   = free_top_r;
    fresh_next_nxt = fresh_next_r;
    count_nxt      = count_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;

    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    out_count_nxt  = out_count_r;

    val_we     = 1'b0;
    val_waddr  = s_r;
    nxt_we     = 1'b0;
    nxt_waddr  = s_r;
    nxt_wdata  = NULL_LINK;
    node_raddr = head_r[SW-1:0];
    free_we    = 1'b0;
    free_waddr = free_top_r[SW-1:0];
    free_raddr = free_top_dec[SW-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          front_nxt    = (in_op == alle_pkg::OP_FRONT);
          val_nxt      = in_value_ext[VALUE_BITS-1:0];
          res_status_nxt = alle_pkg::ST_DONE;
          res_slot_nxt   = '0;
          prev_nxt     = NULL_LINK;
          p_nxt        = head_r;
          if (in_is_insert) begin
            if (free_top_r != '0) begin
              state_nxt = S_POP;
            end else if (fresh_next_r < NULL_LINK) begin
              s_nxt          = fresh_next_r[SW-1:0];
              fresh_next_nxt = fresh_next_r + 1'b1;
              state_nxt      = S_LINK;
            end else begin
              res_status_nxt = alle_pkg::ST_FULL;
              state_nxt      = S_FIN;
            end
          end else if (head_r >= NULL_LINK) begin
            res_status_nxt = alle_pkg::ST_NOT_FOUND;
            state_nxt      = S_FIN;
          end else begin
            state_nxt = S_DEL;
          end
        end
      end
      S_POP: begin
        s_nxt        = free_rdata;
        free_top_nxt = free_top_dec;
        state_nxt    = S_LINK;
      end
      S_LINK: begin
        val_we = 1'b1;
        nxt_we = 1'b1;
        if (front_r || (head_r >= NULL_LINK)) begin
          nxt_wdata    = head_r;
          head_nxt     = LW'(s_r);
          count_nxt    = count_r + 1'b1;
          res_slot_nxt = s_r;
          state_nxt    = S_FIN;
        end else begin
          // New tail gets a null link; the walk starts at the head.
          nxt_wdata = NULL_LINK;
          p_nxt     = head_r;
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        if (next_is_null) begin
          nxt_we       = 1'b1;
          nxt_waddr    = p_r[SW-1:0];
          nxt_wdata    = LW'(s_r);
          count_nxt    = count_r + 1'b1;
          res_slot_nxt = s_r;
          state_nxt    = S_FIN;
        end else begin
          p_nxt      = nxt_rdata;
          node_raddr = nxt_rdata[SW-1:0];
        end
      end
      S_DEL: begin
        if (val_rdata == val_r) begin
          if (prev_r >= NULL_LINK) begin
            head_nxt = nxt_rdata;
          end else begin
            nxt_we    = 1'b1;
            nxt_waddr = prev_r[SW-1:0];
            nxt_wdata = nxt_rdata;
          end
          if (free_top_r < NULL_LINK) begin
            free_we      = 1'b1;
            free_top_nxt = free_top_r + 1'b1;
          end
          if (count_r != '0) begin
            count_nxt = count_r - 1'b1;
          end
          res_slot_nxt = p_r[SW-1:0];
          state_nxt    = S_FIN;
        end else if (next_is_null) begin
          res_status_nxt = alle_pkg::ST_NOT_FOUND;
          state_nxt      = S_FIN;
        end else begin
          prev_nxt   = p_r;
          p_nxt      = nxt_rdata;
          node_raddr = nxt_rdata[SW-1:0];
        end
      end
      S_FIN: begin
        if (out_room) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_slot_nxt   = (res_status_r == alle_pkg::ST_DONE) ?
                           alle_pkg::SLOT_W'(res_slot_r) : '0;
          out_count_nxt  = alle_pkg::COUNT_W'(count_r);
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      head_r       <= NULL_LINK;
      free_top_r   <= '0;
      fresh_next_r <= '0;
      count_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      head_r       <= head_nxt;
      free_top_r   <= free_top_nxt;
      fresh_next_r <= fresh_next_nxt;
      count_r      <= count_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    front_r      <= front_nxt;
    val_r        <= val_nxt;
    s_r          <= s_nxt;
    p_r          <= p_nxt;
    prev_r       <= prev_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_slot   = out_slot_r;
  assign out_count  = out_count_r;

endmodule

// File: sim/alle_tb_pkg.sv
// Scoreboard for the array linked list engine: list predictor and result checking.
`timescale 1ns / 1ps

package alle_tb_pkg;
  import alle_pkg::*;

  localparam int unsigned NODES = SLOTS_DEF;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [COUNT_W-1:0]  count;
  } list_result_t;

  class list_scoreboard;
    logic [IN_VAL_W-1:0] node_value [NODES];
    int unsigned         node_next  [NODES];
    int unsigned         free_stack [NODES];
    int unsigned         free_depth;
    int unsigned         fresh_slot;
    int unsigned         head;
    int unsigned         nodes_in_list;
    list_result_t        awaited [$];
    int unsigned         failures;

    function new();
      free_depth    = 0;
      fresh_slot    = 0;
      head          = NODES;
      nodes_in_list = 0;
      failures      = 0;
    endfunction

    // Freed slots go first, last freed first; then never-used slots in order.
    function bit take_slot(output int unsigned s);
      s = 0;
      if (free_depth > 0) begin
        free_depth--;
        s = free_stack[free_depth];
        return 1'b1;
      end
      if (fresh_slot < NODES) begin
        s = fresh_slot;
        fresh_slot++;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction

    // Value held by the node at the given position, counted from the head.
    function logic [IN_VAL_W-1:0] value_at(int unsigned depth);
      int unsigned p;
      p = head;
      for (int unsigned i = 0; i < depth && p < NODES; i++)
        p = node_next[p];
      return (p < NODES) ? node_value[p] : '0;
    endfunction

    function void note_request(logic [OP_W-1:0] op, logic [IN_VAL_W-1:0] value);
      list_result_t r;
      int unsigned  s;
      int unsigned  p;
      int unsigned  prev;
      int unsigned  steps;
      bit           found;
      r.status = ST_DONE;
      r.slot   = '0;
      if (op == OP_FRONT || op == OP_REAR) begin
        if (!take_slot(s)) begin
          r.status = ST_FULL;
        end else begin
          node_value[s] = value;
          if (op == OP_FRONT || head >= NODES) begin
            node_next[s] = head;
            head = s;
          end else begin
            node_next[s] = NODES;
            p = head;
            steps = 0;
            while (steps < NODES && node_next[p] < NODES) begin
              p = node_next[p];
              steps++;
            end
            node_next[p] = s;
          end
          nodes_in_list++;
          r.slot = s[SLOT_W-1:0];
        end
      end else begin
        // Delete, which the spare op code also selects.
        r.status = ST_NOT_FOUND;
        prev  = NODES;
        p     = head;
        steps = 0;
        found = 1'b0;
        while (!found && steps < NODES && p < NODES) begin
          if (node_value[p] == value) begin
            if (prev >= NODES) head = node_next[p];
            else               node_next[prev] = node_next[p];
            node_next[p] = NODES;
            if (free_depth < NODES) begin
              free_stack[free_depth] = p;
              free_depth++;
            end
            if (nodes_in_list > 0) nodes_in_list--;
            r.status = ST_DONE;
            r.slot   = p[SLOT_W-1:0];
            found    = 1'b1;
          end else begin
            prev = p;
            p    = node_next[p];
            steps++;
          end
        end
      end
      r.count = nodes_in_list[COUNT_W-1:0];
      awaited.push_back(r);
    endfunction

    function void compare_field(string field, int unsigned expected, logic [15:0] actual);
      if (actual !== expected[15:0]) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, expected, actual);
        failures++;
      end
    endfunction

    function void check_result(logic [STATUS_W-1:0] status, logic [SLOT_W-1:0] slot,
                               logic [COUNT_W-1:0] count);
      list_result_t r;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result, expected none, got status %0d slot %0d count %0d",
                 $time, status, slot, count);
        failures++;
        return;
      end
      r = awaited.pop_front();
      compare_field("status", r.status, 16'(status));
      compare_field("slot", r.slot, 16'(slot));
      compare_field("count", r.count, 16'(count));
    endfunction
  endclass

endpackage

// File: sim/tb_array_linked_list_engine.sv
// Testbench top for the array linked list engine: stimulus, handshakes and verdict.
`timescale 1ns / 1ps

module tb_array_linked_list_engine;
  import alle_pkg::*;
  import alle_tb_pkg::*;

  // The spare op code, which the block treats as a delete.
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

  // The limit allows every one of roughly 600 transactions a full walk of the
  // list plus the longest gaps on both sides, and then some.
  localparam int unsigned LIMIT_CYCLES = 4_000_000;
  localparam int unsigned POOL_SIZE    = 12;

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_stall;
  logic [OP_W-1:0]            in_op;
  logic signed [IN_VAL_W-1:0] in_value;
  logic                       out_valid;
  logic                       out_stall;
  logic [STATUS_W-1:0]        out_status;
  logic [SLOT_W-1:0]          out_slot;
  logic [COUNT_W-1:0]         out_count;

  list_scoreboard      sb;
  logic [IN_VAL_W-1:0] value_pool [POOL_SIZE];
  bit                  steady_sender;

  array_linked_list_engine DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_op      (in_op),
    .in_value   (in_value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_status (out_status),
    .out_slot   (out_slot),
    .out_count  (out_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Every result transaction is checked against the oldest prediction. Outputs
  // are sampled at the rising edge, before the block's own updates land.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_status, out_slot, out_count);
  end

  // The receiver stalls in bursts. Most runs of readiness are short, a few are
  // long stretches with no stall at all, and now and then a stall lasts long
  // enough to hold a finished result in the output register for a while.
  initial begin : result_stall
    int unsigned ready_len;
    int unsigned stall_len;
    int unsigned pick;
    forever begin
      pick = $urandom_range(0, 99);
      if (pick < 70)      ready_len = $urandom_range(1, 4);
      else if (pick < 90) ready_len = $urandom_range(5, 20);
      else                ready_len = $urandom_range(100, 250);
      out_stall <= 1'b0;
      repeat (ready_len) @(posedge clk);
      pick = $urandom_range(0, 99);
      if (pick < 40)      stall_len = 0;
      else if (pick < 85) stall_len = $urandom_range(1, 3);
      else                stall_len = $urandom_range(10, 60);
      if (stall_len > 0) begin
        out_stall <= 1'b1;
        repeat (stall_len) @(posedge clk);
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin : watchdog
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("tb_array_linked_list_engine: FAIL");
    $finish;
  end

  // Idle cycles the sender inserts after a transaction: mostly none or a few,
  // occasionally a long pause. A steady sender never idles.
  function automatic int unsigned pick_gap();
    int unsigned pick;
    if (steady_sender) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Drives one request and holds it steady until the block takes it. The
  // prediction is made at the edge of acceptance, so the predictor always
  // reflects exactly the transactions that the block has taken in. Valid is
  // only lowered when a gap follows, so a back-to-back request keeps it high.
  task automatic send_request(logic [OP_W-1:0] op, logic [IN_VAL_W-1:0] value);
    int unsigned gap;
    in_valid <= 1'b1;
    in_op    <= op;
    in_value <= value;
    do @(posedge clk); while (in_stall);
    sb.note_request(op, value);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // The sender goes quiet until every predicted result has come back. Valid
  // drops at once, since the block would otherwise take the stale request
  // again as soon as it is free.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() > 0);
  endtask

  function automatic logic [IN_VAL_W-1:0] pick_value();
    if ($urandom_range(0, 3) == 0) return $urandom();
    return value_pool[$urandom_range(0, POOL_SIZE - 1)];
  endfunction

  // Deletes mostly name a value that is in the list, at any depth, so that the
  // walk reaches the tail as well as the head.
  function automatic logic [IN_VAL_W-1:0] pick_delete_value();
    if (sb.nodes_in_list > 0 && $urandom_range(0, 9) < 7)
      return sb.value_at($urandom_range(0, sb.nodes_in_list - 1));
    return pick_value();
  endfunction

  // Random traffic around a target list size: inserts dominate while the list is
  // short and deletes once it grows past the cap.
  task automatic run_random(int unsigned items, int unsigned cap);
    int unsigned     pick;
    int unsigned     insert_share;
    logic [OP_W-1:0] op;
    for (int unsigned i = 0; i < items; i++) begin
      if (i % 55 == 0) steady_sender = ($urandom_range(0, 3) == 0);
      if (sb.nodes_in_list < 4)        insert_share = 75;
      else if (sb.nodes_in_list > cap) insert_share = 25;
      else                             insert_share = 50;
      pick = $urandom_range(0, 99);
      if (pick < 6)                     op = OP_SPARE;
      else if (pick < 6 + insert_share) op = $urandom_range(0, 1) ? OP_REAR : OP_FRONT;
      else                              op = OP_DELETE;
      if (op == OP_FRONT || op == OP_REAR) send_request(op, pick_value());
      else                                 send_request(op, pick_delete_value());
    end
    steady_sender = 1'b0;
  endtask

  initial begin : stimulus
    sb            = new();
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_op         = OP_FRONT;
    in_value      = '0;
    steady_sender = 1'b0;

    // The pool keeps values recurring so that deletes find matches and
    // duplicates occur; the extremes of the value range are always in it.
    value_pool[0] = 32'h0000_0000;
    value_pool[1] = 32'hFFFF_FFFF;
    value_pool[2] = 32'h7FFF_FFFF;
    value_pool[3] = 32'h8000_0000;
    value_pool[4] = 32'h0000_0001;
    for (int i = 5; i < POOL_SIZE; i++) value_pool[i] = $urandom();

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed opening. A delete and the spare op code on the empty list find
    // nothing; a rear insert into the empty list becomes the head.
    send_request(OP_DELETE, 32'h0000_0005);
    send_request(OP_SPARE,  32'h0000_0005);
    send_request(OP_REAR,   32'h8000_0000);
    send_request(OP_FRONT,  32'h7FFF_FFFF);
    send_request(OP_REAR,   32'hFFFF_FFFF);
    send_request(OP_FRONT,  32'h0000_0000);
    send_request(OP_REAR,   32'h5555_5555);
    send_request(OP_FRONT,  32'hAAAA_AAAA);
    send_request(OP_REAR,   32'h7FFF_FFFF);
    // A duplicated value: the first match goes, in the middle of the list, then
    // the head, then the copy left at the tail.
    send_request(OP_DELETE, 32'h7FFF_FFFF);
    send_request(OP_DELETE, 32'hAAAA_AAAA);
    send_request(OP_DELETE, 32'h7FFF_FFFF);
    send_request(OP_DELETE, 32'h1234_5678);
    send_request(OP_SPARE,  32'hFFFF_FFFF);
    // Freed slots come back last freed first, before any never-used slot.
    send_request(OP_FRONT,  32'h0F0F_0F0F);
    send_request(OP_REAR,   32'hF0F0_F0F0);
    send_request(OP_REAR,   32'h0000_0001);
    send_request(OP_FRONT,  32'h8000_0000);
    send_request(OP_DELETE, 32'h8000_0000);
    send_request(OP_FRONT,  32'h0000_FFFF);
    send_request(OP_DELETE, 32'h0000_0000);
    wait_drained();

    // Random traffic on a short list, with a full drain part-way through.
    run_random(200, 40);
    wait_drained();
    run_random(180, 24);
    wait_drained();

    // Grow the list so that the walks below are long ones.
    while (sb.nodes_in_list < 48)
      send_request(($urandom_range(0, 3) == 0) ? OP_FRONT : OP_REAR, pick_value());

    // Long walks: the tail, an absent value over the whole list, and deletes at
    // random depths, each followed by an insert that mostly walks to the end.
    send_request(OP_DELETE, sb.value_at(sb.nodes_in_list - 1));
    send_request(OP_REAR,   $urandom());
    send_request(OP_DELETE, 32'h1234_5678);
    for (int unsigned i = 0; i < 18; i++) begin
      send_request(OP_DELETE, sb.value_at($urandom_range(0, sb.nodes_in_list - 1)));
      send_request(($urandom_range(0, 3) == 0) ? OP_FRONT : OP_REAR, $urandom());
    end

    // Drain from the head until the list is empty, leaving the used slots on
    // the free stack.
    while (sb.nodes_in_list > 0)
      send_request(($urandom_range(0, 7) == 0) ? OP_SPARE : OP_DELETE, sb.value_at(0));
    send_request(OP_DELETE, 32'hFFFF_FFFF);
    wait_drained();

    // A short tail of random traffic that starts on recycled slots.
    run_random(60, 16);

    wait_drained();
    repeat (NODES + 50) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0)
      $display("tb_array_linked_list_engine: PASS");
    else
      $display("tb_array_linked_list_engine: FAIL");
    $finish;
  end

endmodule
